>>> sv/b64le_pkg.sv
// Shared types, character codes and helper functions of the base64 line encoder.
`timescale 1ns / 1ps

package b64le_pkg;

    localparam logic [1:0] MODE_NEWLINE = 2'd0;
    localparam logic [1:0] MODE_ESCAPE  = 2'd1;
    localparam logic [1:0] MODE_FLAT    = 2'd2;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_PAD  = 8'h3D;  // '='
    localparam logic [7:0] CH_PLUS = 8'h2B;  // '+'
    localparam logic [7:0] CH_PCT  = 8'h25;  // '%'

    // Slot positions inside one record, in emission order
    localparam int SLOT_NL_PRE  = 0;
    localparam int SLOT_SYM0    = 1;
    localparam int SLOT_SYM1    = 2;
    localparam int SLOT_PAD1    = 3;
    localparam int SLOT_PAD2    = 4;
    localparam int SLOT_NL_POST = 5;
    localparam int NUM_SLOTS    = 6;

    localparam logic [1:0] SUB_PCT    = 2'd0;
    localparam logic [1:0] SUB_DIGIT  = 2'd1;
    localparam logic [1:0] SUB_LETTER = 2'd2;

    // Characters caused by one input byte, before escaping
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [7:0]           c0;
        logic [7:0]           c1;
    } t_rec;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = 8'(v) + 8'h41;
        end else if (v < 6'd52) begin
            ch = 8'(v) + 8'h47;           // 'a' - 26
        end else if (v < 6'd62) begin
            ch = 8'(v) - 8'h04;           // '0' - 52
        end else if (v == 6'd62) begin
            ch = CH_PLUS;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

    function automatic logic needs_escape(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_PAD) || (c == CH_NL);
    endfunction

    // One character of the percent triplet for an escaped symbol
    function automatic logic [7:0] esc_char(input logic [7:0] c, input logic [1:0] sub);
        logic [7:0] ch;
        unique case (sub)
            SUB_PCT:   ch = CH_PCT;
            SUB_DIGIT: ch = (c == CH_PLUS) ? 8'h32 : ((c == CH_PAD) ? 8'h33 : 8'h30);
            default:   ch = (c == CH_PLUS) ? 8'h42 : ((c == CH_PAD) ? 8'h44 : 8'h41);
        endcase
        return ch;
    endfunction

endpackage

>>> sv/b64le_front.sv
// Front end: takes raw bytes, tracks group phase and line fill, builds records.
`timescale 1ns / 1ps

module b64le_front import b64le_pkg::*; #(
    parameter int CHARS_PER_LINE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_lines,
    output t_rec       o_rec
);

    localparam int PER_LINE = CHARS_PER_LINE / 4;
    localparam int GW       = (PER_LINE > 1) ? $clog2(PER_LINE) : 1;

    logic [1:0]    r_phase,   n_phase;
    logic [3:0]    r_carry,   n_carry;
    logic [GW-1:0] r_groups,  n_groups;
    logic          r_nl_pend, n_nl_pend;

    logic          line_full;

    assign line_full = (r_groups == GW'(PER_LINE - 1));

    always_comb begin
        o_rec                    = '0;
        o_rec.mask[SLOT_NL_PRE]  = r_nl_pend;
        o_rec.mask[SLOT_SYM0]    = 1'b1;
        o_rec.mask[SLOT_NL_POST] = i_last_byte && i_lines;
        n_phase   = r_phase;
        n_carry   = r_carry;
        n_groups  = r_groups;
        n_nl_pend = 1'b0;
        case (r_phase)
            2'd0: begin
                o_rec.c0              = b64_sym(i_data_byte[7:2]);
                o_rec.c1              = b64_sym({i_data_byte[1:0], 4'b0000});
                o_rec.mask[SLOT_SYM1] = i_last_byte;
                o_rec.mask[SLOT_PAD1] = i_last_byte;
                o_rec.mask[SLOT_PAD2] = i_last_byte;
                n_carry               = {2'b00, i_data_byte[1:0]};
                n_phase               = 2'd1;
            end
            2'd1: begin
                o_rec.c0              = b64_sym({r_carry[1:0], i_data_byte[7:4]});
                o_rec.c1              = b64_sym({i_data_byte[3:0], 2'b00});
                o_rec.mask[SLOT_SYM1] = i_last_byte;
                o_rec.mask[SLOT_PAD1] = i_last_byte;
                n_carry               = i_data_byte[3:0];
                n_phase               = 2'd2;
            end
            default: begin
                o_rec.c0              = b64_sym({r_carry, i_data_byte[7:6]});
                o_rec.c1              = b64_sym(i_data_byte[5:0]);
                o_rec.mask[SLOT_SYM1] = 1'b1;
                n_carry               = 4'h0;
                n_phase               = 2'd0;
                if (line_full) begin
                    n_groups  = '0;
                    n_nl_pend = i_lines && !i_last_byte;
                end else begin
                    n_groups  = r_groups + GW'(1);
                end
            end
        endcase
        // end of message: start over
        if (i_last_byte) begin
            n_phase   = 2'd0;
            n_carry   = 4'h0;
            n_groups  = '0;
            n_nl_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 2'd0;
            r_carry   <= 4'h0;
            r_groups  <= '0;
            r_nl_pend <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_carry   <= n_carry;
            r_groups  <= n_groups;
            r_nl_pend <= n_nl_pend;
        end
    end

endmodule

>>> sv/b64le_queue.sv
// Two-entry record queue between the front end and the character sequencer.
`timescale 1ns / 1ps

module b64le_queue import b64le_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_rec i_rec,
    input  logic i_rd,
    output t_rec o_rec,
    output logic o_valid,
    output logic o_full
);

    t_rec       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_rec   = r_mem[r_rptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wptr <= !r_wptr;
            end
            if (i_rd) begin
                r_rptr <= !r_rptr;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/b64le_back.sv
// Back end: walks each record slot by slot, expands escapes, one character per cycle unless the output stalls.
`timescale 1ns / 1ps

module b64le_back import b64le_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_escape,
    input  t_rec       i_rec,
    input  logic       i_rec_valid,
    output logic       o_rec_pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_last,
    input  logic       i_out_pop
);

    logic                 r_busy;
    logic [NUM_SLOTS-1:0] r_mask;
    logic [7:0]           r_c0;
    logic [7:0]           r_c1;
    logic [1:0]           r_sub;
    logic                 r_out_valid;
    logic [7:0]           r_out_char;
    logic                 r_out_last;

    logic                 can_go;
    logic                 emit;
    logic [NUM_SLOTS-1:0] low_bit;
    logic [NUM_SLOTS-1:0] mask_rest;
    logic [7:0]           cur_c;
    logic                 esc;
    logic [7:0]           emit_char;
    logic                 slot_done;
    logic                 rec_done;
    logic                 load;

    assign can_go    = !r_out_valid || i_out_pop;
    assign emit      = r_busy && can_go;
    assign low_bit   = r_mask & (~r_mask + NUM_SLOTS'(1));
    assign mask_rest = r_mask & ~low_bit;

    always_comb begin
        unique case (low_bit)
            NUM_SLOTS'(1) << SLOT_SYM0: cur_c = r_c0;
            NUM_SLOTS'(1) << SLOT_SYM1: cur_c = r_c1;
            NUM_SLOTS'(1) << SLOT_PAD1,
            NUM_SLOTS'(1) << SLOT_PAD2: cur_c = CH_PAD;
            default:                    cur_c = CH_NL;
        endcase
    end

    assign esc       = i_escape && needs_escape(cur_c);
    assign emit_char = esc ? esc_char(cur_c, r_sub) : cur_c;
    assign slot_done = !esc || (r_sub == SUB_LETTER);
    assign rec_done  = slot_done && (mask_rest == '0);
    // take the next record when idle, or right as the current one finishes
    assign load      = i_rec_valid && (!r_busy || (emit && rec_done));
    assign o_rec_pop = load;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= rec_done;
        end
        if (load) begin
            r_c0 <= i_rec.c0;
            r_c1 <= i_rec.c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mask      <= '0;
            r_sub       <= SUB_PCT;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_mask <= i_rec.mask;
                r_sub  <= SUB_PCT;
            end else if (emit) begin
                if (slot_done) begin
                    r_mask <= mask_rest;
                    r_sub  <= SUB_PCT;
                end else begin
                    r_sub  <= r_sub + 2'd1;
                end
                if (rec_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

>>> sv/base64_encoder_line_escape_top.sv
// Top level of the streaming base64 encoder with line breaks and percent escapes.
// A byte's first character passes the record queue, back-end and output registers
// before it is visible. Throughput: one output character per cycle while the
// output is popped, set by the back-end sequencer. A new byte is taken every cycle
// while the two-entry record queue has room. Synchronous active-low reset clears
// phase, line count, queue and mode (mode 0).
`timescale 1ns / 1ps

module base64_encoder_line_escape_top import b64le_pkg::*; #(
    parameter int CHARS_PER_LINE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_last_char,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_line_mode
);

    logic [1:0] r_line_mode;
    logic       lines;
    logic       escape;
    logic       accept;
    t_rec       front_rec;
    t_rec       q_rec;
    logic       q_valid;
    logic       q_full;
    logic       q_pop;
    logic       out_valid;

    assign o_cfg_ready = 1'b1;
    assign lines       = (r_line_mode != MODE_FLAT);
    assign escape      = (r_line_mode == MODE_ESCAPE);
    assign full        = q_full;
    assign accept      = push && !q_full;
    assign empty       = !out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= MODE_NEWLINE;
        end else if (i_cfg_valid) begin
            r_line_mode <= i_cfg_line_mode;
        end
    end

    b64le_front #(
        .CHARS_PER_LINE (CHARS_PER_LINE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_lines     (lines),
        .o_rec       (front_rec)
    );

    b64le_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_rec   (front_rec),
        .i_rd    (q_pop),
        .o_rec   (q_rec),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    b64le_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_escape    (escape),
        .i_rec       (q_rec),
        .i_rec_valid (q_valid),
        .o_rec_pop   (q_pop),
        .o_out_valid (out_valid),
        .o_out_char  (o_out_char),
        .o_out_last  (o_last_char),
        .i_out_pop   (pop)
    );

endmodule

>>> sim/base64_line_checker.sv
// Watches the encoder's channels, predicts the base64 text and compares every character.
`timescale 1ns / 1ps

module base64_line_checker import b64le_pkg::*; #(
    parameter int CHARS_PER_LINE = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [7:0] i_out_char,
    input  logic       i_last_char,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_line_mode,
    output int         o_mismatches,
    output int         o_pending_chars
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    t_enc_char  pending_chars[$];
    logic [1:0] line_mode;
    logic [1:0] phase;
    logic [3:0] carry;
    int         groups;
    logic       nl_held;
    int         mismatches;
    string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    assign o_mismatches = mismatches;

    function automatic void queue_char(input logic [7:0] c);
        string esc;
        if (line_mode == MODE_ESCAPE && (c == CH_PLUS || c == CH_PAD || c == CH_NL)) begin
            esc = (c == CH_PLUS) ? "2B" : ((c == CH_PAD) ? "3D" : "0A");
            pending_chars.push_back('{ch: CH_PCT, last: 1'b0});
            pending_chars.push_back('{ch: esc[0], last: 1'b0});
            pending_chars.push_back('{ch: esc[1], last: 1'b0});
        end else begin
            pending_chars.push_back('{ch: c, last: 1'b0});
        end
    endfunction

    function automatic void queue_sym(input logic [5:0] v);
        queue_char(alphabet[v]);
    endfunction

    // Expand one accepted byte into the characters it releases
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        logic lines;
        lines = (line_mode != MODE_FLAT);
        if (nl_held) begin
            queue_char(CH_NL);
            nl_held = 1'b0;
        end
        if (phase == 2'd0) begin
            queue_sym(b[7:2]);
            carry = {2'b00, b[1:0]};
            phase = 2'd1;
            if (fin) begin
                queue_sym({carry[1:0], 4'b0000});
                queue_char(CH_PAD);
                queue_char(CH_PAD);
            end
        end else if (phase == 2'd1) begin
            queue_sym({carry[1:0], b[7:4]});
            carry = b[3:0];
            phase = 2'd2;
            if (fin) begin
                queue_sym({carry, 2'b00});
                queue_char(CH_PAD);
            end
        end else begin
            queue_sym({carry, b[7:6]});
            queue_sym(b[5:0]);
            carry = 4'd0;
            phase = 2'd0;
            groups++;
            if (groups >= CHARS_PER_LINE / 4) begin
                groups = 0;
                if (lines && !fin) nl_held = 1'b1;
            end
        end
        if (fin) begin
            if (lines) queue_char(CH_NL);
            phase = 2'd0;
            carry = 4'd0;
            groups = 0;
            nl_held = 1'b0;
        end
        pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    function automatic void flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endfunction

    always @(posedge i_clk) begin
        t_enc_char want;
        if (!i_rst_n) begin
            pending_chars.delete();
            line_mode = MODE_NEWLINE;
            phase = 2'd0;
            carry = 4'd0;
            groups = 0;
            nl_held = 1'b0;
            mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) line_mode = i_cfg_line_mode;
            if (i_push && !i_full) encode_byte(i_data_byte, i_last_byte);
            if (i_pop && !i_empty) begin
                if (pending_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected character 0x%0h", $realtime, i_out_char);
                end else begin
                    want = pending_chars.pop_front();
                    if (i_out_char !== want.ch)
                        flag_mismatch("out_char", int'(want.ch), int'(i_out_char));
                    if (i_last_char !== want.last)
                        flag_mismatch("last_char", int'(want.last), int'(i_last_char));
                end
            end
        end
        // registered so the stimulus side reads it race-free
        o_pending_chars <= pending_chars.size();
    end

endmodule

>>> sim/tb_base64_encoder_line_escape_top.sv
// Stimulus and verdict for the base64 line encoder, with the character checker beside it.
`timescale 1ns / 1ps

module tb_base64_encoder_line_escape_top;
    import b64le_pkg::*;

    localparam int         LINE_CHARS       = 64;
    localparam int         QUIET_LIMIT      = 5000;
    localparam int         ITEM_TARGET      = 180;
    localparam logic [1:0] MODE_NEWLINE_ALT = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_last_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_char;
    logic       o_last_char;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_line_mode = 2'd0;

    int   mismatches;
    int   pending_chars;
    int   bytes_sent = 0;
    int   quiet_cycles = 0;
    logic calm = 1'b0;

    base64_encoder_line_escape_top #(.CHARS_PER_LINE(LINE_CHARS)) dut (.*);

    base64_line_checker #(.CHARS_PER_LINE(LINE_CHARS)) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_out_char     (o_out_char),
        .i_last_char    (o_last_char),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_line_mode(i_cfg_line_mode),
        .o_mismatches   (mismatches),
        .o_pending_chars(pending_chars)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("base64_encoder_line_escape_top verification failed");
            $finish;
        end
    end

    // Hold push high until the transfer; leave it high for the caller to reuse or drop
    task automatic feed_byte(input logic [7:0] b, input logic fin);
        calm = (bytes_sent >= 100 && bytes_sent < 150);
        if (!calm && $urandom_range(0, 99) < 17) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Drain the encoder before touching the mode
    task automatic write_line_mode(input logic [1:0] m);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_chars != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_line_mode <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic feed_bytes(input logic [7:0] bytes[$], input logic ends_message);
        foreach (bytes[i]) feed_byte(bytes[i], ends_message && (i == bytes.size() - 1));
    endtask

    task automatic feed_random_message(input int len);
        for (int i = 0; i < len; i++) begin
            // a finished line leaves a newline held; switch modes there often
            if (i > 0 && (((i % 48) == 0 && $urandom_range(0, 1) == 1)
                          || $urandom_range(0, 99) < 2))
                write_line_mode(2'($urandom_range(0, 3)));
            feed_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    initial begin
        int pick;
        int len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset mode: single bytes of extreme value, then a '+' and a full group
        feed_bytes('{8'h00}, 1'b1);
        feed_bytes('{8'hFF}, 1'b1);
        feed_bytes('{8'hFB, 8'hFF}, 1'b1);
        feed_bytes('{8'hFB, 8'hEF, 8'hBE}, 1'b1);
        write_line_mode(MODE_ESCAPE);
        feed_bytes('{8'hFB, 8'hFF}, 1'b1);
        feed_bytes('{8'h00}, 1'b1);
        // switch modes in the middle of a message
        feed_bytes('{8'hFB}, 1'b0);
        write_line_mode(MODE_FLAT);
        feed_bytes('{8'hEF, 8'hBE}, 1'b1);
        write_line_mode(MODE_NEWLINE_ALT);
        feed_bytes('{8'hFF, 8'h00}, 1'b1);
        write_line_mode(MODE_NEWLINE);

        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 30) write_line_mode(2'($urandom_range(0, 3)));
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                len = $urandom_range(1, 6);
            end else if (pick < 87) begin
                len = ($urandom_range(0, 1) == 1) ? 96 : 48;
            end else begin
                len = $urandom_range(45, 70);
            end
            feed_random_message(len);
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (pending_chars != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_chars == 0) begin
            $display("base64_encoder_line_escape_top verification clean");
        end else begin
            $display("base64_encoder_line_escape_top verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/b64le_pkg.sv
sv/b64le_front.sv
sv/b64le_queue.sv
sv/b64le_back.sv
sv/base64_encoder_line_escape_top.sv
sim/base64_line_checker.sv
sim/tb_base64_encoder_line_escape_top.sv
